/* design/atb_pkg.sv */
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types and constants of the ATA task-file builder: register select
// codes, status codes, configuration register indexes and the stage records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atb_pkg;

	// Drive slots the register map has room for
	localparam int MaxSlots = 4;
	localparam int DriveSlotsDefault = 4;

	// Configuration bus
	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;

	// Task-file register select codes
	typedef enum logic [3:0] {
		REG_CONTROL  = 4'd0,
		REG_DEVSEL   = 4'd1,
		REG_SECCNT_H = 4'd2,
		REG_LBA3     = 4'd3,
		REG_LBA4     = 4'd4,
		REG_LBA5     = 4'd5,
		REG_SECCNT   = 4'd6,
		REG_LBA0     = 4'd7,
		REG_LBA1     = 4'd8,
		REG_LBA2     = 4'd9,
		REG_COMMAND  = 4'd10
	} reg_sel_t;

	// Request status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DRIVE = 2'd1,
		ST_RANGE    = 2'd2,
		ST_ATAPI    = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_PRESENT  = 3'd0,
		CFG_ATAPI    = 3'd1,
		CFG_LBA      = 3'd2,
		CFG_LOCATION = 3'd3,
		CFG_SECT0    = 3'd4,
		CFG_SECT1    = 3'd5,
		CFG_SECT2    = 3'd6,
		CFG_SECT3    = 3'd7
	} cfg_idx_t;

	// Task-file byte constants
	localparam logic [7:0] CtrlNoIrq  = 8'h02;
	localparam logic [7:0] DevselLba  = 8'hE0;
	localparam logic [7:0] DevselChs  = 8'hA0;
	localparam logic [7:0] CmdRead    = 8'h20;
	localparam logic [7:0] CmdWrite   = 8'h30;
	localparam logic [7:0] CmdExtBit  = 8'h04;

	// Division by 63 sectors per track: q = (lba * Recip63) >> Recip63Shift,
	// low by at most one, fixed up by a single compare and subtract.
	localparam int SectorsPerTrack = 63;
	localparam logic [31:0] Recip63 = 32'd2181570690;
	localparam int Recip63Shift = 37;
	localparam int QuotWidth = 64 - Recip63Shift;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [3:0]                      present;
		logic [3:0]                      atapi;
		logic [3:0]                      lba_cap;
		logic [7:0]                      location;
		logic [MaxSlots-1:0][31:0]       sectors;
	} cfg_t;

	// Finished request handed to the output serializer
	typedef struct packed {
		status_t    status;
		logic       chan;
		logic       lba48;
		logic [7:0] devsel;
		logic [7:0] lba_hi;
		logic [7:0] cnt;
		logic [7:0] l0;
		logic [7:0] l1;
		logic [7:0] l2;
		logic [7:0] cmdb;
	} desc_t;

endpackage

/* design/ata_taskfile_builder.sv */
// ----------------------------------------------------------------------------
// ata_taskfile_builder
// Turns read/write sector requests into ATA task-file register writes. A
// request (cmd, drive, lba, sector_count) is checked against the configured
// presence, ATAPI and capacity registers; a failing request yields a single
// result carrying its status. A good one yields control, device select, the
// four high-order writes when the address needs LBA48, sector count, LBA0..2
// and the command byte: 11 results for LBA48, 7 for LBA28 or CHS, 1 for an
// error, one result per cycle while rsp_stall is low. The output serializer
// sets the rate: it issues all results of one request before it takes
// another, while the three-stage address pipeline in front keeps up to three
// further requests in flight. Registers are written through the APB port at
// byte address 4*index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_taskfile_builder #(
	parameter int DRIVE_SLOTS = atb_pkg::DriveSlotsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [atb_pkg::AddrWidth-1:0] paddr,
	input  logic [atb_pkg::DataWidth-1:0] pwdata,
	output logic [atb_pkg::DataWidth-1:0] prdata,
	output logic                          pready,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          cmd,
	input  logic [1:0]                    drive,
	input  logic [31:0]                   lba,
	input  logic [7:0]                    sector_count,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          channel,
	output logic [3:0]                    reg_select,
	output logic [7:0]                    value,
	output logic [1:0]                    status,
	output logic                          last
);
	import atb_pkg::*;

	cfg_t  cfg;
	logic  req_ready;
	logic  desc_valid;
	logic  desc_ready;
	desc_t desc;

	assign pready    = 1'b1;
	assign req_stall = !req_ready;

	atb_cfg_regs #(
		.DRIVE_SLOTS(DRIVE_SLOTS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	atb_addr_pipe #(
		.DRIVE_SLOTS(DRIVE_SLOTS)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.cmd         (cmd),
		.drive       (drive),
		.lba         (lba),
		.sector_count(sector_count),
		.desc_valid  (desc_valid),
		.desc_ready  (desc_ready),
		.desc        (desc)
	);

	atb_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc_ready(desc_ready),
		.desc      (desc),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.channel   (channel),
		.reg_select(reg_select),
		.value     (value),
		.status    (status),
		.last      (last)
	);

endmodule

/* design/atb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// atb_cfg_regs
// APB-style register file: drive presence, ATAPI and LBA masks, drive
// location and per-slot capacities.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atb_cfg_regs #(
	parameter int DRIVE_SLOTS = atb_pkg::DriveSlotsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [atb_pkg::AddrWidth-1:0] paddr,
	input  logic [atb_pkg::DataWidth-1:0] pwdata,
	output logic [atb_pkg::DataWidth-1:0] prdata,
	output atb_pkg::cfg_t                 cfg
);
	import atb_pkg::*;

	logic       wr_en;
	cfg_idx_t   idx;
	logic [3:0] present_q;
	logic [3:0] atapi_q;
	logic [3:0] lba_cap_q;
	logic [7:0] location_q;
	logic [MaxSlots-1:0][31:0] sectors_q;

	assign wr_en = psel && penable && pwrite;
	assign idx   = cfg_idx_t'(paddr[AddrWidth-1:2]);

	// Mask and location registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			atapi_q    <= '0;
			lba_cap_q  <= '0;
			location_q <= '0;
		end else if (wr_en) begin
			case (idx)
				CFG_PRESENT:  present_q  <= pwdata[3:0];
				CFG_ATAPI:    atapi_q    <= pwdata[3:0];
				CFG_LBA:      lba_cap_q  <= pwdata[3:0];
				CFG_LOCATION: location_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Capacity registers exist only for the slots that are built
	for (genvar g = 0; g < MaxSlots; g++) begin : g_sect
		localparam cfg_idx_t SlotIdx = cfg_idx_t'(int'(CFG_SECT0) + g);
		if (g < DRIVE_SLOTS) begin : g_on
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sectors_q[g] <= '0;
				end else if (wr_en && idx == SlotIdx) begin
					sectors_q[g] <= pwdata;
				end
			end
		end else begin : g_off
			assign sectors_q[g] = '0;
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			CFG_PRESENT:  prdata = DataWidth'(present_q);
			CFG_ATAPI:    prdata = DataWidth'(atapi_q);
			CFG_LBA:      prdata = DataWidth'(lba_cap_q);
			CFG_LOCATION: prdata = DataWidth'(location_q);
			CFG_SECT0:    prdata = sectors_q[0];
			CFG_SECT1:    prdata = sectors_q[1];
			CFG_SECT2:    prdata = sectors_q[2];
			CFG_SECT3:    prdata = sectors_q[3];
			default:      prdata = '0;
		endcase
	end

	assign cfg.present  = present_q;
	assign cfg.atapi    = atapi_q;
	assign cfg.lba_cap  = lba_cap_q;
	assign cfg.location = location_q;
	assign cfg.sectors  = sectors_q;

endmodule

/* design/atb_addr_pipe.sv */
// ----------------------------------------------------------------------------
// atb_addr_pipe
// Three-stage request pipeline: drive checks and reciprocal multiply, CHS
// remainder estimate, then fix-up and task-file byte assembly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atb_addr_pipe #(
	parameter int DRIVE_SLOTS = atb_pkg::DriveSlotsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  atb_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          cmd,
	input  logic [1:0]    drive,
	input  logic [31:0]   lba,
	input  logic [7:0]    sector_count,
	output logic          desc_valid,
	input  logic          desc_ready,
	output atb_pkg::desc_t desc
);
	import atb_pkg::*;

	// Stage 1 registers
	logic                 v_s1;
	logic                 cmd_s1;
	logic [31:0]          lba_s1;
	logic [7:0]           cnt_s1;
	status_t              status_s1;
	logic                 slave_s1;
	logic                 chan_s1;
	logic                 lbamode_s1;
	logic [QuotWidth-1:0] q_s1;

	// Stage 2 registers
	logic                 v_s2;
	logic                 cmd_s2;
	logic [31:0]          lba_s2;
	logic [7:0]           cnt_s2;
	status_t              status_s2;
	logic                 slave_s2;
	logic                 chan_s2;
	logic                 lbamode_s2;
	logic [QuotWidth-1:0] q_s2;
	logic [6:0]           r_s2;

	// Stage 3 registers
	logic                 v_s3;
	desc_t                desc_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	// Stage 1 combinational
	status_t              status_c1;
	logic                 slot_ok;
	logic [32:0]          end_lba;
	logic [63:0]          prod;

	// Stage 2 combinational
	logic [6:0]           r_c2;

	// Stage 3 combinational
	logic                 fix;
	logic [5:0]           rem_c3;
	logic [QuotWidth-1:0] q_c3;
	logic [7:0]           sect;
	logic                 lba48;
	desc_t                desc_c3;

	// Flow control: a stage takes new data when empty or when it moves on
	assign rdy_s3    = !v_s3 || desc_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	// Drive checks, bounds sum and reciprocal multiply
	always_comb begin
		slot_ok = ({1'b0, drive} < 3'(DRIVE_SLOTS)) && cfg.present[drive];
		end_lba = {1'b0, lba} + {25'b0, sector_count};
		if (!slot_ok) begin
			status_c1 = ST_NO_DRIVE;
		end else if (cfg.atapi[drive]) begin
			status_c1 = ST_ATAPI;
		end else if (end_lba > {1'b0, cfg.sectors[drive]}) begin
			status_c1 = ST_RANGE;
		end else begin
			status_c1 = ST_OK;
		end
		prod = 64'(lba) * 64'(Recip63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			cmd_s1     <= cmd;
			lba_s1     <= lba;
			cnt_s1     <= sector_count;
			status_s1  <= status_c1;
			slave_s1   <= cfg.location[{drive, 1'b0}];
			chan_s1    <= cfg.location[{drive, 1'b1}];
			lbamode_s1 <= cfg.lba_cap[drive];
			q_s1       <= prod[63:Recip63Shift];
		end
	end

	// Remainder estimate lba - 63*q, exact in 7 bits since it stays below 126
	assign r_c2 = lba_s1[6:0] - {q_s1[0], 6'b0} + q_s1[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			cmd_s2     <= cmd_s1;
			lba_s2     <= lba_s1;
			cnt_s2     <= cnt_s1;
			status_s2  <= status_s1;
			slave_s2   <= slave_s1;
			chan_s2    <= chan_s1;
			lbamode_s2 <= lbamode_s1;
			q_s2       <= q_s1;
			r_s2       <= r_c2;
		end
	end

	// Quotient fix-up and task-file byte assembly
	always_comb begin
		fix    = r_s2 >= 7'(SectorsPerTrack);
		rem_c3 = fix ? 6'(r_s2 - 7'(SectorsPerTrack)) : r_s2[5:0];
		q_c3   = q_s2 + QuotWidth'(fix);
		sect   = {2'b0, rem_c3} + 8'd1;
		lba48  = lba_s2[31:28] != 4'd0;

		desc_c3        = '0;
		desc_c3.status = status_s2;
		desc_c3.chan   = chan_s2;
		desc_c3.lba48  = lba48;
		desc_c3.lba_hi = lba_s2[31:24];
		desc_c3.cnt    = cnt_s2;
		desc_c3.cmdb   = (cmd_s2 ? CmdWrite : CmdRead) | (lba48 ? CmdExtBit : 8'h00);
		if (lba48) begin
			desc_c3.devsel = DevselLba | {3'b0, slave_s2, 4'b0};
			desc_c3.l0     = lba_s2[7:0];
			desc_c3.l1     = lba_s2[15:8];
			desc_c3.l2     = lba_s2[23:16];
		end else if (lbamode_s2) begin
			desc_c3.devsel = DevselLba | {3'b0, slave_s2, lba_s2[27:24]};
			desc_c3.l0     = lba_s2[7:0];
			desc_c3.l1     = lba_s2[15:8];
			desc_c3.l2     = lba_s2[23:16];
		end else begin
			// CHS: head is q mod 16, cylinder q / 16
			desc_c3.devsel = DevselChs | {3'b0, slave_s2, q_c3[3:0]};
			desc_c3.l0     = sect;
			desc_c3.l1     = q_c3[11:4];
			desc_c3.l2     = q_c3[19:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			desc_s3 <= desc_c3;
		end
	end

	assign desc_valid = v_s3;
	assign desc       = desc_s3;

endmodule

/* design/atb_serializer.sv */
// ----------------------------------------------------------------------------
// atb_serializer
// Walks one finished request through its task-file writes, one per cycle
// while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atb_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           desc_valid,
	output logic           desc_ready,
	input  atb_pkg::desc_t desc,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic           channel,
	output logic [3:0]     reg_select,
	output logic [7:0]     value,
	output logic [1:0]     status,
	output logic           last
);
	import atb_pkg::*;

	desc_t      desc_q;
	logic       desc_vld_q;
	reg_sel_t   step_q;
	reg_sel_t   step_nxt;

	logic       rsp_valid_q;
	logic       chan_q;
	logic [3:0] reg_q;
	logic [7:0] value_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       err;
	logic       out_free;
	logic       issue;
	logic       item_last;
	logic [7:0] item_val;

	// Issue control
	always_comb begin
		err        = desc_q.status != ST_OK;
		out_free   = !rsp_valid_q || !rsp_stall;
		issue      = desc_vld_q && out_free;
		item_last  = err || step_q == REG_COMMAND;
		desc_ready = !desc_vld_q || (issue && item_last);
		if (step_q == REG_DEVSEL && !desc_q.lba48) begin
			step_nxt = REG_SECCNT;
		end else begin
			step_nxt = reg_sel_t'(step_q + 4'd1);
		end
	end

	// Byte for the current register
	always_comb begin
		case (step_q)
			REG_CONTROL:  item_val = CtrlNoIrq;
			REG_DEVSEL:   item_val = desc_q.devsel;
			REG_SECCNT_H: item_val = 8'h00;
			REG_LBA3:     item_val = desc_q.lba_hi;
			REG_LBA4:     item_val = 8'h00;
			REG_LBA5:     item_val = 8'h00;
			REG_SECCNT:   item_val = desc_q.cnt;
			REG_LBA0:     item_val = desc_q.l0;
			REG_LBA1:     item_val = desc_q.l1;
			REG_LBA2:     item_val = desc_q.l2;
			REG_COMMAND:  item_val = desc_q.cmdb;
			default:      item_val = 8'h00;
		endcase
	end

	// Request holding register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_vld_q <= 1'b0;
			step_q     <= REG_CONTROL;
		end else if (desc_ready) begin
			desc_vld_q <= desc_valid;
			step_q     <= REG_CONTROL;
		end else if (issue) begin
			step_q <= step_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			desc_q <= desc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chan_q   <= err ? 1'b0 : desc_q.chan;
			reg_q    <= err ? 4'(REG_CONTROL) : 4'(step_q);
			value_q  <= err ? 8'h00 : item_val;
			status_q <= 2'(desc_q.status);
			last_q   <= item_last;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign channel    = chan_q;
	assign reg_select = reg_q;
	assign value      = value_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

/* design/atb_checker.sv */
// ----------------------------------------------------------------------------
// atb_checker
// Port-level checks of the task-file builder result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic       channel,
	input logic [3:0] reg_select,
	input logic [7:0] value,
	input logic [1:0] status,
	input logic       last
);
	import atb_pkg::*;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(value) && $stable(reg_select)
			&& $stable(status) && $stable(last) && $stable(channel))
		else $error("stalled result changed");

	// An error request is a single all-zero write marked last
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != 2'(ST_OK) |-> last && reg_select == 4'(REG_CONTROL)
			&& value == 8'h00 && !channel)
		else $error("malformed error result");

	// The command write closes the request, and only it does on success
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == 2'(ST_OK) |-> last == (reg_select == 4'(REG_COMMAND)))
		else $error("last flag does not match command write");

	// Writes of one request follow without a gap on the same channel
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !last |=> rsp_valid && $stable(channel)
			&& status == 2'(ST_OK))
		else $error("gap or channel change inside a request");

endmodule

bind ata_taskfile_builder atb_checker u_atb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.channel   (channel),
	.reg_select(reg_select),
	.value     (value),
	.status    (status),
	.last      (last)
);

/* tb/sv/taskfile_checker.sv */
// ----------------------------------------------------------------------------
// taskfile_checker
// Watches the configuration port and both request and result channels of the
// ATA task-file builder. Keeps its own copy of the drive tables, expands
// every accepted request into the task-file writes it must produce and
// compares each accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module taskfile_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [atb_pkg::AddrWidth-1:0] paddr,
	input  logic [atb_pkg::DataWidth-1:0] pwdata,
	input  logic                          pready,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic                          cmd,
	input  logic [1:0]                    drive,
	input  logic [31:0]                   lba,
	input  logic [7:0]                    sector_count,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic                          channel,
	input  logic [3:0]                    reg_select,
	input  logic [7:0]                    value,
	input  logic [1:0]                    status,
	input  logic                          last,
	output int                            mismatches,
	output int                            pending
);
	import atb_pkg::*;

	// One task-file register write as seen on the result channel
	typedef struct packed {
		logic       chan;
		reg_sel_t   sel;
		logic [7:0] val;
		status_t    st;
		logic       fin;
	} tf_write_t;

	tf_write_t   due_writes[$];

	// Local copy of the drive tables
	logic [3:0]  present_mask;
	logic [3:0]  atapi_mask;
	logic [3:0]  lba_mask;
	logic [7:0]  location;
	logic [31:0] capacity[MaxSlots];

	initial begin
		mismatches = 0;
		pending = 0;
		present_mask = '0;
		atapi_mask = '0;
		lba_mask = '0;
		location = '0;
		for (int i = 0; i < MaxSlots; i++)
			capacity[i] = '0;
	end

	task automatic add_write(input logic chan, input reg_sel_t sel, input logic [7:0] val,
			input status_t st, input logic fin);
		tf_write_t w;
		w.chan = chan;
		w.sel = sel;
		w.val = val;
		w.st = st;
		w.fin = fin;
		due_writes.push_back(w);
	endtask

	// Expand one request into its task-file writes
	task automatic expand_request(input logic wr, input logic [1:0] d, input logic [31:0] addr,
			input logic [7:0] cnt);
		logic        slave;
		logic        chan;
		logic        ext;
		logic [7:0]  devsel;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  opcode;
		logic [31:0] sect;
		logic [31:0] base;
		logic [31:0] cyl;
		logic [31:0] head;

		if (!present_mask[d]) begin
			add_write(1'b0, REG_CONTROL, 8'h00, ST_NO_DRIVE, 1'b1);
			return;
		end
		if (atapi_mask[d]) begin
			add_write(1'b0, REG_CONTROL, 8'h00, ST_ATAPI, 1'b1);
			return;
		end
		// bounds sum carries into bit 32, no wrap
		if (({1'b0, addr} + 33'(cnt)) > {1'b0, capacity[d]}) begin
			add_write(1'b0, REG_CONTROL, 8'h00, ST_RANGE, 1'b1);
			return;
		end

		slave = location[2*d];
		chan = location[2*d+1];
		ext = (addr >= 32'h1000_0000);

		if (ext) begin
			devsel = DevselLba | {3'b000, slave, 4'h0};
			b0 = addr[7:0];
			b1 = addr[15:8];
			b2 = addr[23:16];
		end else if (lba_mask[d]) begin
			devsel = DevselLba | {3'b000, slave, addr[27:24]};
			b0 = addr[7:0];
			b1 = addr[15:8];
			b2 = addr[23:16];
		end else begin
			// CHS: 63 sectors per track, 16 heads
			sect = addr % 63 + 1;
			base = addr + 1 - sect;
			cyl = base / (16 * 63);
			head = (base % (16 * 63)) / 63;
			devsel = DevselChs | {3'b000, slave, head[3:0]};
			b0 = sect[7:0];
			b1 = cyl[7:0];
			b2 = cyl[15:8];
		end

		opcode = wr ? CmdWrite : CmdRead;
		if (ext)
			opcode = opcode | CmdExtBit;

		add_write(chan, REG_CONTROL, CtrlNoIrq, ST_OK, 1'b0);
		add_write(chan, REG_DEVSEL, devsel, ST_OK, 1'b0);
		if (ext) begin
			add_write(chan, REG_SECCNT_H, 8'h00, ST_OK, 1'b0);
			add_write(chan, REG_LBA3, addr[31:24], ST_OK, 1'b0);
			add_write(chan, REG_LBA4, 8'h00, ST_OK, 1'b0);
			add_write(chan, REG_LBA5, 8'h00, ST_OK, 1'b0);
		end
		add_write(chan, REG_SECCNT, cnt, ST_OK, 1'b0);
		add_write(chan, REG_LBA0, b0, ST_OK, 1'b0);
		add_write(chan, REG_LBA1, b1, ST_OK, 1'b0);
		add_write(chan, REG_LBA2, b2, ST_OK, 1'b0);
		add_write(chan, REG_COMMAND, opcode, ST_OK, 1'b1);
	endtask

	// Compare one result with the oldest write due
	task automatic check_write();
		tf_write_t want;
		if (due_writes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result ch=%0d sel=%0d val=%02h st=%0d last=%0d",
					$realtime, channel, reg_select, value, status, last);
			return;
		end
		want = due_writes.pop_front();
		if (want.chan !== channel || want.sel !== reg_sel_t'(reg_select) ||
				want.val !== value || want.st !== status_t'(status) || want.fin !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result mismatch exp ch=%0d sel=%0d val=%02h st=%0d last=%0d,",
					$realtime, want.chan, want.sel, want.val, want.st, want.fin,
					" got ch=%0d sel=%0d val=%02h st=%0d last=%0d",
					channel, reg_select, value, status, last);
		end
	endtask

	// Everything is sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (cfg_idx_t'(paddr[4:2]))
					CFG_PRESENT:  present_mask = pwdata[3:0];
					CFG_ATAPI:    atapi_mask = pwdata[3:0];
					CFG_LBA:      lba_mask = pwdata[3:0];
					CFG_LOCATION: location = pwdata[7:0];
					CFG_SECT0:    capacity[0] = pwdata;
					CFG_SECT1:    capacity[1] = pwdata;
					CFG_SECT2:    capacity[2] = pwdata;
					CFG_SECT3:    capacity[3] = pwdata;
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				expand_request(cmd, drive, lba, sector_count);
			if (rsp_valid && !rsp_stall)
				check_write();
			pending = due_writes.size();
		end
	end

endmodule

/* tb/sv/tb_ata_taskfile_builder.sv */
// ----------------------------------------------------------------------------
// tb_ata_taskfile_builder
// Drives sector requests into the task-file builder under several drive
// table settings: a directed set for addressing modes, boundaries and each
// error, then random phases of mostly valid requests. Both channels idle at
// random, with one calm stretch and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ata_taskfile_builder;
	import atb_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	logic                 req_valid;
	logic                 req_stall;
	logic                 cmd;
	logic [1:0]           drive;
	logic [31:0]          lba;
	logic [7:0]           sector_count;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic                 channel;
	logic [3:0]           reg_select;
	logic [7:0]           value;
	logic [1:0]           status;
	logic                 last;

	int                   mismatches;
	int                   pending;
	int                   sent_count;
	bit                   calm;
	logic [31:0]          caps[MaxSlots];

	ata_taskfile_builder dut (.*);

	taskfile_checker u_checker (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#1ms;
		$display("FAIL ata_taskfile_builder");
		$finish;
	end

	// Result side: random stalls, one long hold-off once the pipe is busy
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_used && sent_count >= 120) begin
				hold_used = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else
				rsp_stall = !calm && ($urandom_range(0, 99) < 6);
		end
	end

	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx >= CFG_SECT0)
			caps[idx - CFG_SECT0] = data;
	endtask

	// Offer one request and hold it until accepted
	task automatic send_request(input logic c, input logic [1:0] d, input logic [31:0] a,
			input logic [7:0] n);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 6) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid = 1'b1;
		cmd = c;
		drive = d;
		lba = a;
		sector_count = n;
		do @(posedge clk); while (req_stall);
		sent_count++;
	endtask

	// Drop valid and wait until every result due has come back
	task automatic settle(input int extra);
		@(negedge clk);
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Stimulus
	initial begin
		logic        c;
		logic [1:0]  d;
		logic [31:0] a;
		logic [7:0]  n;
		int          kind;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		cmd = 1'b0;
		drive = '0;
		lba = '0;
		sector_count = '0;
		sent_count = 0;
		calm = 0;
		for (int i = 0; i < MaxSlots; i++)
			caps[i] = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// tables still at reset: nothing present
		send_request(1'b0, 2'd0, 32'd0, 8'd1);
		settle(8);

		// slots 0 and 2 LBA-capable, 1 and 3 CHS only; one slot per location
		cfg_write(CFG_PRESENT, 32'hF);
		cfg_write(CFG_ATAPI, 32'h0);
		cfg_write(CFG_LBA, 32'h5);
		cfg_write(CFG_LOCATION, 32'hE4);
		cfg_write(CFG_SECT0, 32'hFFFF_FFFF);
		cfg_write(CFG_SECT1, 32'hFFFF_FFFF);
		cfg_write(CFG_SECT2, 32'd1000);
		cfg_write(CFG_SECT3, 32'hFFFF_FFFF);

		send_request(1'b0, 2'd0, 32'd0, 8'd0);
		send_request(1'b1, 2'd0, 32'hFFFF_FF00, 8'hFF);
		send_request(1'b0, 2'd0, 32'hFFFF_FFFF, 8'd1);     // sum reaches 2^32
		send_request(1'b1, 2'd0, 32'h0FFF_FFFF, 8'd0);
		send_request(1'b0, 2'd0, 32'h1000_0000, 8'd1);
		send_request(1'b0, 2'd1, 32'd0, 8'd1);
		send_request(1'b1, 2'd1, 32'd62, 8'd8);
		send_request(1'b0, 2'd1, 32'd63, 8'd8);
		send_request(1'b0, 2'd1, 32'd1007, 8'd3);
		send_request(1'b1, 2'd1, 32'd1008, 8'd3);
		send_request(1'b0, 2'd1, 32'h0FFF_FFFF, 8'd0);
		send_request(1'b1, 2'd1, 32'hF000_0001, 8'd2);     // CHS slot, LBA48 address
		send_request(1'b0, 2'd2, 32'd999, 8'd1);
		send_request(1'b1, 2'd2, 32'd999, 8'd2);
		send_request(1'b0, 2'd2, 32'd1000, 8'd0);
		send_request(1'b1, 2'd3, 32'hAAAA_5555, 8'h5A);
		send_request(1'b0, 2'd3, 32'h5555_AAAA, 8'hA5);
		settle(8);

		// missing slots, ATAPI slot, empty capacity
		cfg_write(CFG_PRESENT, 32'h6);
		cfg_write(CFG_ATAPI, 32'h4);
		cfg_write(CFG_LBA, 32'hF);
		cfg_write(CFG_LOCATION, 32'hFF);
		cfg_write(CFG_SECT1, 32'h0);

		send_request(1'b0, 2'd0, 32'd5, 8'd1);
		send_request(1'b1, 2'd3, 32'd5, 8'd1);
		send_request(1'b1, 2'd2, 32'hFFFF_FFFF, 8'hFF);
		send_request(1'b0, 2'd1, 32'd0, 8'd0);
		send_request(1'b1, 2'd1, 32'd0, 8'd1);
		settle(8);

		// random phases, mostly requests that pass the checks
		for (int phase = 0; phase < 6; phase++) begin
			cfg_write(CFG_PRESENT, (phase == 5) ? 32'hF
				: 32'(4'hF & ~(($urandom_range(0, 2) == 0) ? (4'h1 << $urandom_range(0, 3)) : 4'h0)));
			cfg_write(CFG_ATAPI, ($urandom_range(0, 3) == 0) ? 32'(4'h1 << $urandom_range(0, 3)) : 32'h0);
			cfg_write(CFG_LBA, (phase == 4) ? 32'h0 : (phase == 5) ? 32'hF : 32'($urandom_range(0, 15)));
			cfg_write(CFG_LOCATION, (phase == 4) ? 32'hFF : (phase == 5) ? 32'h0
				: 32'($urandom_range(0, 255)));
			for (int s = 0; s < MaxSlots; s++) begin
				kind = $urandom_range(0, 3);
				cfg_write(cfg_idx_t'(CFG_SECT0 + s), (kind < 2) ? 32'hFFFF_FFFF
					: (kind == 2) ? $urandom : 32'($urandom_range(0, 5000)));
			end

			calm = (phase == 2);
			for (int k = 0; k < 60; k++) begin
				c = 1'($urandom_range(0, 1));
				d = 2'($urandom_range(0, 3));
				n = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 3))
					0: a = $urandom_range(0, 5000);
					1: a = $urandom & 32'h0FFF_FFFF;
					2: a = $urandom | 32'h1000_0000;
					default: a = 32'h0FFF_FFFE + $urandom_range(0, 3);
				endcase
				kind = $urandom_range(0, 9);
				if (kind < 8) begin
					// pull the request inside the slot's capacity
					if (({1'b0, a} + 33'(n)) > {1'b0, caps[d]}) begin
						if (caps[d] < 32'(n)) begin
							n = caps[d][7:0];
							a = '0;
						end else
							a = caps[d] - 32'(n);
					end
				end else
					a = $urandom;
				send_request(c, d, a, n);
			end
			settle(8);
		end
		calm = 0;

		if (mismatches == 0 && pending == 0)
			$display("PASS ata_taskfile_builder");
		else
			$display("FAIL ata_taskfile_builder");
		$finish;
	end

endmodule

/* files.f */
design/atb_pkg.sv
design/atb_cfg_regs.sv
design/atb_addr_pipe.sv
design/atb_serializer.sv
design/ata_taskfile_builder.sv
design/atb_checker.sv
tb/sv/taskfile_checker.sv
tb/sv/tb_ata_taskfile_builder.sv
